// File: rtl/core/acw_pkg.sv
// shared types and character constants for the console writer
package acw_pkg;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_NONE    = 2'd0;
  localparam kind_t KIND_GLYPH   = 2'd1;
  localparam kind_t KIND_ADVANCE = 2'd2;

  localparam logic [7:0] CSI_OPEN  = 8'h9B;
  localparam logic [7:0] FINAL_MIN = 8'h40;
  localparam logic [7:0] NEWLINE   = 8'd10;
  localparam logic [7:0] FINAL_P   = 8'h70;
  localparam logic [7:0] FINAL_M   = 8'h6D;
  localparam logic [7:0] DIGIT_0   = 8'h30;
  localparam logic [7:0] DIGIT_1   = 8'h31;
  localparam logic [7:0] SGR_LO    = 8'd30;
  localparam logic [7:0] SGR_HI    = 8'd37;
  localparam logic [7:0] SGR_BIAS  = 8'd29;
  localparam logic [7:0] TEN       = 8'd10;

  localparam logic [3:0] STYLE_PLAIN = 4'd0;
  localparam logic [3:0] STYLE_MAX   = 4'd8;

endpackage

// File: rtl/core/ansi_csi_console_writer.sv
// console text writer with a small csi sgr interpreter
//
// Usage: one byte of console text enters per transaction on the in_ channel
// (in_valid, in_stall, in_char_code). Every accepted byte gives exactly one
// result transaction on the out_ channel: a glyph write (kind 1) with line,
// column and style, a line advance (kind 2) at the old position, or
// nothing visible (kind 0) for csi bytes, always with the current style
// and cursor visibility after the byte.
// The result of an accepted byte is registered and shown from the next cycle
// on. Throughput is one byte per cycle while out_ is not stalled; the
// running state (csi flags, parameters, style, cursor) is updated in the
// cycle of acceptance, so the next byte can follow at once.
// in_stall is high only while a result is held and the receiver stalls
// out_; a held result stays put until taken and the next byte is taken in
// the same cycle that the held result leaves.
// Reset (rst_n low, synchronous) closes any csi sequence, clears the
// parameters, selects plain style, hides the cursor, puts the cursor at
// line 0 column 0 and empties the result register.
module ansi_csi_console_writer #(
  parameter int LINE_COUNT  = 128,
  parameter int LINE_LENGTH = 128,
  parameter int PARAM_LIMIT = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_char_value,
  output logic [3:0] out_style,
  output logic [6:0] out_line_index,
  output logic [6:0] out_column,
  output logic       out_cursor_visible
);

  localparam int LINE_W  = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
  localparam int COL_W   = (LINE_LENGTH > 1) ? $clog2(LINE_LENGTH) : 1;
  localparam int CNT_W   = $clog2(PARAM_LIMIT + 1);
  localparam int LINE_XW = (LINE_W > 7) ? LINE_W : 7;
  localparam int COL_XW  = (COL_W > 7) ? COL_W : 7;
  localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(LINE_COUNT - 1);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(LINE_LENGTH - 1);
  localparam logic [CNT_W-1:0]  CNT_LIMIT = CNT_W'(PARAM_LIMIT);
  localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0]  CNT_TWO   = CNT_W'(2);

  // running state
  logic              in_escape_r, in_escape_nxt;
  logic [CNT_W-1:0]  param_count_r, param_count_nxt;
  logic [7:0]        param_first_r, param_first_nxt;
  logic [7:0]        param_second_r, param_second_nxt;
  logic [3:0]        style_r, style_nxt;
  logic [LINE_W-1:0] cursor_line_r, cursor_line_nxt;
  logic [COL_W-1:0]  cursor_column_r, cursor_column_nxt;
  logic              cursor_shown_r, cursor_shown_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  acw_pkg::kind_t    out_kind_r, kind_nxt;
  logic [7:0]        out_char_r, char_nxt;
  logic [3:0]        out_style_r;
  logic [6:0]        out_line_r, out_col_r;
  logic              out_vis_r;

  logic              in_fire;
  logic              advance;
  logic [7:0]        sgr_tens;
  logic [7:0]        sgr_value;
  logic [LINE_XW-1:0] line_ext;
  logic [COL_XW-1:0]  col_ext;

  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;

  assign advance = (in_char_code == acw_pkg::NEWLINE) || (cursor_column_r >= COL_LAST);

  // two-digit sgr value, wrapping at 8 bits
  assign sgr_tens  = 8'((param_first_r - acw_pkg::DIGIT_0) * acw_pkg::TEN);
  assign sgr_value = sgr_tens + (param_second_r - acw_pkg::DIGIT_0);

  assign line_ext = LINE_XW'(cursor_line_r);
  assign col_ext  = COL_XW'(cursor_column_r);

  always_comb begin
    in_escape_nxt     = in_escape_r;
    param_count_nxt   = param_count_r;
    param_first_nxt   = param_first_r;
    param_second_nxt  = param_second_r;
    style_nxt         = style_r;
    cursor_line_nxt   = cursor_line_r;
    cursor_column_nxt = cursor_column_r;
    cursor_shown_nxt  = cursor_shown_r;
    kind_nxt          = acw_pkg::KIND_NONE;
    char_nxt          = 8'd0;
    if (advance) begin
      // csi state is left as it is across a line advance
      kind_nxt          = acw_pkg::KIND_ADVANCE;
      cursor_line_nxt   = (cursor_line_r == LINE_LAST) ? '0 : cursor_line_r + 1'b1;
      cursor_column_nxt = '0;
    end else if (!in_escape_r) begin
      if (in_char_code == acw_pkg::CSI_OPEN) begin
        in_escape_nxt = 1'b1;
      end else begin
        kind_nxt          = acw_pkg::KIND_GLYPH;
        char_nxt          = in_char_code;
        cursor_column_nxt = cursor_column_r + 1'b1;
      end
    end else if (in_char_code >= acw_pkg::FINAL_MIN) begin
      if (in_char_code == acw_pkg::FINAL_P) begin
        if (param_count_r == CNT_TWO) begin
          if (param_first_r == acw_pkg::DIGIT_0) begin
            cursor_shown_nxt = 1'b0;
          end else if (param_first_r == acw_pkg::DIGIT_1) begin
            cursor_shown_nxt = 1'b1;
          end
        end
      end else if (in_char_code == acw_pkg::FINAL_M) begin
        if (param_count_r == CNT_ONE) begin
          if (param_first_r == acw_pkg::DIGIT_0) begin
            style_nxt = acw_pkg::STYLE_PLAIN;
          end
        end else if (param_count_r == CNT_TWO) begin
          if (sgr_value >= acw_pkg::SGR_LO && sgr_value <= acw_pkg::SGR_HI) begin
            style_nxt = 4'(sgr_value - acw_pkg::SGR_BIAS);
          end
        end
      end
      in_escape_nxt   = 1'b0;
      param_count_nxt = '0;
    end else if (param_count_r < CNT_LIMIT) begin
      if (param_count_r == '0) begin
        param_first_nxt = in_char_code;
      end else if (param_count_r == CNT_ONE) begin
        param_second_nxt = in_char_code;
      end
      param_count_nxt = param_count_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_escape_r     <= 1'b0;
      param_count_r   <= '0;
      param_first_r   <= '0;
      param_second_r  <= '0;
      style_r         <= acw_pkg::STYLE_PLAIN;
      cursor_line_r   <= '0;
      cursor_column_r <= '0;
      cursor_shown_r  <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        in_escape_r     <= in_escape_nxt;
        param_count_r   <= param_count_nxt;
        param_first_r   <= param_first_nxt;
        param_second_r  <= param_second_nxt;
        style_r         <= style_nxt;
        cursor_line_r   <= cursor_line_nxt;
        cursor_column_r <= cursor_column_nxt;
        cursor_shown_r  <= cursor_shown_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_kind_r  <= kind_nxt;
      out_char_r  <= char_nxt;
      out_style_r <= style_nxt;
      out_line_r  <= line_ext[6:0];
      out_col_r   <= col_ext[6:0];
      out_vis_r   <= cursor_shown_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_char_value     = out_char_r;
  assign out_style          = out_style_r;
  assign out_line_index     = out_line_r;
  assign out_column         = out_col_r;
  assign out_cursor_visible = out_vis_r;

  // outside csi no parameters are pending
  a_count_idle : assert property (@(posedge clk) disable iff (!rst_n)
    !in_escape_r |-> param_count_r == '0)
    else $error("parameter count set outside csi");

  a_count_sat : assert property (@(posedge clk) disable iff (!rst_n)
    param_count_r <= CNT_LIMIT)
    else $error("parameter count beyond limit");

  a_advance_col : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && advance |=> cursor_column_r == '0)
    else $error("column not cleared on line advance");

  a_char_kind : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r != acw_pkg::KIND_GLYPH |-> out_char_r == 8'd0)
    else $error("non-glyph transaction carries a character");

  a_style_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_style_r <= acw_pkg::STYLE_MAX)
    else $error("style out of range");

endmodule

// File: tb/console_write_checker.sv
// checker for the console writer: follows both channels, predicts each write and compares
module console_write_checker #(
  parameter int LINE_COUNT  = 128,
  parameter int LINE_LENGTH = 128,
  parameter int PARAM_LIMIT = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_kind,
  input  logic [7:0] out_char_value,
  input  logic [3:0] out_style,
  input  logic [6:0] out_line_index,
  input  logic [6:0] out_column,
  input  logic       out_cursor_visible,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    acw_pkg::kind_t kind;
    logic [7:0]     glyph;
    logic [3:0]     style;
    logic [6:0]     row;
    logic [6:0]     col;
    logic           shown;
  } console_write_t;

  // console state as the writer should hold it
  logic        csi_open;
  int unsigned param_count;
  logic [7:0]  param_first;
  logic [7:0]  param_second;
  logic [3:0]  cur_style;
  int unsigned cur_row;
  int unsigned cur_col;
  logic        cursor_shown;

  console_write_t expected_writes [$];
  int             errors;

  function automatic console_write_t console_step(input logic [7:0] c);
    console_write_t w;
    logic [7:0]     sgr;
    w.kind  = acw_pkg::KIND_NONE;
    w.glyph = 8'd0;
    w.row   = 7'(cur_row);
    w.col   = 7'(cur_col);
    // a newline or a full line wins over any csi handling
    if (c == acw_pkg::NEWLINE || cur_col >= LINE_LENGTH - 1) begin
      w.kind  = acw_pkg::KIND_ADVANCE;
      cur_row = (cur_row + 1) % LINE_COUNT;
      cur_col = 0;
    end else if (!csi_open) begin
      if (c == acw_pkg::CSI_OPEN) begin
        csi_open = 1'b1;
      end else begin
        w.kind  = acw_pkg::KIND_GLYPH;
        w.glyph = c;
        cur_col = cur_col + 1;
      end
    end else if (c >= acw_pkg::FINAL_MIN) begin
      if (c == acw_pkg::FINAL_P) begin
        if (param_count == 2) begin
          if (param_first == acw_pkg::DIGIT_0) cursor_shown = 1'b0;
          else if (param_first == acw_pkg::DIGIT_1) cursor_shown = 1'b1;
        end
      end else if (c == acw_pkg::FINAL_M) begin
        if (param_count == 1) begin
          if (param_first == acw_pkg::DIGIT_0) cur_style = acw_pkg::STYLE_PLAIN;
        end else if (param_count == 2) begin
          // wraps modulo 256 on purpose
          sgr = 8'((param_first - acw_pkg::DIGIT_0) * acw_pkg::TEN
                   + (param_second - acw_pkg::DIGIT_0));
          if (sgr >= acw_pkg::SGR_LO && sgr <= acw_pkg::SGR_HI) begin
            cur_style = 4'(sgr - acw_pkg::SGR_BIAS);
          end
        end
      end
      csi_open    = 1'b0;
      param_count = 0;
    end else if (param_count < PARAM_LIMIT) begin
      if (param_count == 0) param_first = c;
      else if (param_count == 1) param_second = c;
      param_count = param_count + 1;
    end
    w.style = cur_style;
    w.shown = cursor_shown;
    return w;
  endfunction

  task automatic check_field(input string name, input int unsigned exp, input int unsigned act);
    if (exp != act) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    console_write_t w;
    if (!rst_n) begin
      csi_open     = 1'b0;
      param_count  = 0;
      param_first  = 8'd0;
      param_second = 8'd0;
      cur_style    = acw_pkg::STYLE_PLAIN;
      cur_row      = 0;
      cur_col      = 0;
      cursor_shown = 1'b0;
      expected_writes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_writes.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0h char %0h",
                   $time, out_kind, out_char_value);
          errors++;
        end else begin
          w = expected_writes.pop_front();
          check_field("kind", w.kind, out_kind);
          check_field("char_value", w.glyph, out_char_value);
          check_field("style", w.style, out_style);
          check_field("line_index", w.row, out_line_index);
          check_field("column", w.col, out_column);
          check_field("cursor_visible", w.shown, out_cursor_visible);
        end
      end
      if (in_valid && !in_stall) expected_writes.push_back(console_step(in_char_code));
    end
    fail_count <= errors;
    pending    <= expected_writes.size();
  end

endmodule

// File: tb/tb.sv
// testbench top for the console writer: byte stimulus, result stalls and the verdict
module tb;

  localparam int CHAR_TARGET = 1800;
  localparam int CYCLE_LIMIT = 500000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char_code;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_char_value;
  logic [3:0] out_style;
  logic [6:0] out_line_index;
  logic [6:0] out_column;
  logic       out_cursor_visible;

  int fail_count;
  int pending;
  int cycles;
  int chars_sent;
  bit quiet_in;
  bit quiet_out;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ansi_csi_console_writer i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_char_code       (in_char_code),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_char_value     (out_char_value),
    .out_style          (out_style),
    .out_line_index     (out_line_index),
    .out_column         (out_column),
    .out_cursor_visible (out_cursor_visible)
  );

  console_write_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_char_code       (in_char_code),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_char_value     (out_char_value),
    .out_style          (out_style),
    .out_line_index     (out_line_index),
    .out_column         (out_column),
    .out_cursor_visible (out_cursor_visible),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: a fresh stall length for every transaction
  always begin
    int n;
    @(negedge clk);
    n = quiet_out ? 0 : $urandom_range(0, 16);
    if (n > 0) begin
      out_stall <= 1'b1;
      repeat (n) @(negedge clk);
    end
    out_stall <= 1'b0;
    do @(posedge clk); while (!(out_valid && !out_stall));
  end

  // called and returning at a falling edge
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input int len);
    logic [7:0] c;
    repeat (len) begin
      c = 8'($urandom_range(0, 255));
      // keep runs long enough to fill a line
      if (c == acw_pkg::CSI_OPEN || c == acw_pkg::NEWLINE) c = c ^ 8'h01;
      send_char(c);
    end
  endtask

  task automatic send_csi();
    int         n;
    int         pick;
    logic [7:0] c;
    send_char(acw_pkg::CSI_OPEN);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 20) : $urandom_range(0, 2);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 5);
      if (pick == 0) c = 8'($urandom_range(0, 8'h3F));
      else if (k == 0 && pick < 3) c = acw_pkg::DIGIT_0 + 8'd3;
      else if (k == 0 && pick == 3) c = acw_pkg::DIGIT_1;
      else c = acw_pkg::DIGIT_0 + 8'($urandom_range(0, 9));
      send_char(c);
    end
    pick = $urandom_range(0, 9);
    if (pick < 4) send_char(acw_pkg::FINAL_M);
    else if (pick < 7) send_char(acw_pkg::FINAL_P);
    else send_char(8'($urandom_range(acw_pkg::FINAL_MIN, 8'hFF)));
  endtask

  initial begin
    logic [7:0] opening [$];
    int         pick;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_char_code = 8'd0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // extremes, cursor show and hide, colour select and plain, csi inside csi,
    // newline inside an open sequence, and a final byte with no parameters
    opening = '{8'h00, 8'hFF, acw_pkg::NEWLINE,
                acw_pkg::CSI_OPEN, acw_pkg::DIGIT_1, acw_pkg::DIGIT_0 + 8'd5,
                acw_pkg::FINAL_P,
                acw_pkg::CSI_OPEN, acw_pkg::DIGIT_0 + 8'd3, acw_pkg::DIGIT_0 + 8'd7,
                acw_pkg::FINAL_M,
                acw_pkg::CSI_OPEN, acw_pkg::DIGIT_0, acw_pkg::FINAL_M,
                acw_pkg::CSI_OPEN, acw_pkg::DIGIT_0, acw_pkg::DIGIT_0, acw_pkg::FINAL_P,
                acw_pkg::CSI_OPEN, acw_pkg::CSI_OPEN,
                acw_pkg::CSI_OPEN, acw_pkg::NEWLINE, acw_pkg::FINAL_M};
    foreach (opening[i]) send_char(opening[i]);

    while (chars_sent < CHAR_TARGET) begin
      if ($urandom_range(0, 9) == 0) quiet_in = !quiet_in;
      if ($urandom_range(0, 9) == 0) quiet_out = !quiet_out;
      pick = $urandom_range(0, 99);
      if (pick < 5) send_text($urandom_range(120, 140));
      else if (pick < 40) send_text($urandom_range(1, 24));
      else if (pick < 55) repeat ($urandom_range(1, 10)) send_char(acw_pkg::NEWLINE);
      else if (pick < 90) send_csi();
      else send_char(8'($urandom_range(0, 255)));
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/core/acw_pkg.sv
rtl/core/ansi_csi_console_writer.sv
tb/console_write_checker.sv
tb/tb.sv
